[sv/llq_pkg.sv]
// Shared types, codes and defaults for the loss and lag impairment queue.
package llq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_MAX_LEN     = 1500;

	localparam int TIME_W   = 32;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int LEN_W    = 11;
	localparam int HANDLE_W = 4;
	localparam int RAND_W   = 16;
	localparam int LOSS_W   = 16;
	localparam int LAG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOSS_MIN = 2'd0,
		REG_LOSS_MAX = 2'd1,
		REG_LAG_MIN  = 2'd2,
		REG_LAG_MAX  = 2'd3
	} cfg_reg_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_DELIVERED = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_QUEUED    = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// One queued packet descriptor.
	typedef struct packed {
		logic [TIME_W-1:0]   rel_time;
		logic [IP_W-1:0]     ip;
		logic [PORT_W-1:0]   port;
		logic [LEN_W-1:0]    len;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Wrap-safe time order: a is at or after b.
	function automatic logic at_or_after(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return ~d[TIME_W-1];
	endfunction

endpackage

[sv/loss_and_lag_impairment_queue_unit.sv]
// Top level of the loss and lag impairment queue: sequencer, shared arithmetic and entry memory.
//
// Each beat on the slave side is a poll (tuser = 0) or a packet arrival (tuser = 1) and yields
// exactly one result beat on the master side. The block takes one beat at a time and is not
// ready while it works on it. A poll is answered from the head entry, which is read ahead while
// idle and released by moving the head pointer. An arrival that is discarded or passed through
// goes straight to the result, a dropped or refused one after the loss check, and a queued one
// after the lag pick, a scan and an insert: the scan compares one stored release time per cycle
// to find the sorted position, and the insert then moves one entry per cycle through the single
// write port of the entry memory. One 25 by 16 bit multiplier and one bounds unit are shared
// between the loss-rate pick and the lag pick. Results wait in an output register, so a new beat
// is accepted while the previous result is still held. The entry memory needs no clearing after
// reset. Configuration must be written through the cfg channel only while the block is idle;
// the block itself does not enforce this.
module loss_and_lag_impairment_queue_unit #(
	parameter int QUEUE_DEPTH = llq_pkg::DEF_QUEUE_DEPTH,
	parameter int MAX_LEN     = llq_pkg::DEF_MAX_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [llq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [llq_pkg::LAG_W-1:0]      cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: now_ticks, src_ip, src_port, pkt_length, buffer_handle,
	// rand_loss_pick, rand_loss_draw, rand_lag_pick, zero fill.
	input  logic [143:0]                   s_tdata,
	// Fields from bit 0: kind.
	input  logic [0:0]                     s_tuser,
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: out_ip, out_port, out_length, out_handle, zero fill.
	output logic [63:0]                    m_tdata,
	// Fields from bit 0: status.
	output logic [2:0]                     m_tuser
);
	import llq_pkg::*;

	localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SPW = LAG_W + 1;
	localparam int PW  = SPW + RAND_W;
	localparam logic [LW:0] DEPTH_X = (LW+1)'(QUEUE_DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
	localparam logic [15:0] MAX_LEN_W = 16'(MAX_LEN);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_DECODE   = 10'b00_0000_0010,
		S_MUL_LOSS = 10'b00_0000_0100,
		S_LOSS_CHK = 10'b00_0000_1000,
		S_MUL_LAG  = 10'b00_0001_0000,
		S_TIME     = 10'b00_0010_0000,
		S_SCAN     = 10'b00_0100_0000,
		S_SHIFT    = 10'b00_1000_0000,
		S_WRITE    = 10'b01_0000_0000,
		S_EMIT     = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LOSS_W-1:0] loss_min_q, loss_max_q;
	logic [LAG_W-1:0]  lag_min_q, lag_max_q;
	logic              transparent;

	// Captured input beat.
	logic                kind_q;
	logic [TIME_W-1:0]   now_q;
	logic [IP_W-1:0]     ip_q;
	logic [PORT_W-1:0]   port_q;
	logic [LEN_W-1:0]    len_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [RAND_W-1:0]   r_pick_q, r_draw_q, r_lag_q;
	logic [LEN_W-1:0]    in_len;
	logic [LEN_W-1:0]    len_sat;

	// Queue state.
	logic [AW-1:0]  head_q;
	logic [LW-1:0]  occ_q;
	logic [LW-1:0]  pos_q;
	logic [LW-1:0]  j_q;
	logic [TIME_W-1:0] t_q;

	// Shared bounds unit and multiplier.
	logic [LAG_W-1:0] bnd_a, bnd_b, bnd_lo, bnd_hi;
	logic [LAG_W-1:0] lo_q;
	logic [SPW-1:0]   span_q;
	logic [RAND_W-1:0] mul_r;
	logic [PW-1:0]    prod_q;
	logic [SPW-1:0]   pick_w;

	// Entry memory.
	entry_t         mem_q [QUEUE_DEPTH];
	entry_t         rd_q;
	entry_t         wr_data;
	logic           wr_en;
	logic [LW-1:0]  rd_log, wr_log;
	logic [AW-1:0]  rd_addr, wr_addr;
	logic           scan_adv;

	// Result staging and output register.
	status_t             res_status_q;
	logic [IP_W-1:0]     res_ip_q;
	logic [PORT_W-1:0]   res_port_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                m_valid_q;
	logic [63:0]         m_data_q;
	status_t             m_status_q;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [LW-1:0] l);
		logic [LW:0] sum;
		sum = (LW+1)'(head) + (LW+1)'(l);
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	assign transparent = ~|{loss_min_q, loss_max_q, lag_min_q, lag_max_q};
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_status_q;

	assign in_len  = s_tdata[90:80];
	assign len_sat = (16'(in_len) > MAX_LEN_W) ? MAX_LEN_W[LEN_W-1:0] : in_len;

	// Bounds unit: loss bounds while decoding, lag bounds while checking the loss draw.
	always_comb begin
		if (state_q == S_DECODE) begin
			bnd_a = LAG_W'(loss_min_q);
			bnd_b = LAG_W'(loss_max_q);
		end else begin
			bnd_a = lag_min_q;
			bnd_b = lag_max_q;
		end
		bnd_lo = (bnd_a < bnd_b) ? bnd_a : bnd_b;
		bnd_hi = (bnd_a < bnd_b) ? bnd_b : bnd_a;
	end

	assign mul_r  = (state_q == S_MUL_LOSS) ? r_pick_q : r_lag_q;
	assign pick_w = SPW'(lo_q) + prod_q[PW-1:RAND_W];

	// Memory address selection.
	assign scan_adv = (pos_q < occ_q) && at_or_after(t_q, rd_q.rel_time);
	always_comb begin
		rd_log  = '0;
		wr_log  = pos_q;
		wr_en   = 1'b0;
		wr_data = rd_q;
		case (state_q)
			S_SCAN: begin
				if (scan_adv) begin
					rd_log = pos_q + 1'b1;
				end else if (pos_q != occ_q) begin
					rd_log = occ_q - 1'b1;
				end
			end
			S_SHIFT: begin
				wr_en  = 1'b1;
				wr_log = j_q;
				if ((j_q - 1'b1) != pos_q) begin
					rd_log = j_q - LW'(2);
				end
			end
			S_WRITE: begin
				wr_en   = 1'b1;
				wr_data = '{rel_time: t_q, ip: ip_q, port: port_q, len: len_q, handle: handle_q};
			end
			default: begin
				rd_log = '0;
			end
		endcase
	end

	assign rd_addr = phys(head_q, rd_log);
	assign wr_addr = phys(head_q, wr_log);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_min_q <= '0;
			loss_max_q <= '0;
			lag_min_q  <= '0;
			lag_max_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOSS_MIN: loss_min_q <= cfg_data[LOSS_W-1:0];
				REG_LOSS_MAX: loss_max_q <= cfg_data[LOSS_W-1:0];
				REG_LAG_MIN:  lag_min_q  <= cfg_data;
				REG_LAG_MAX:  lag_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q   <= s_tuser[0];
			now_q    <= s_tdata[31:0];
			ip_q     <= s_tdata[63:32];
			port_q   <= s_tdata[79:64];
			len_q    <= len_sat;
			handle_q <= s_tdata[94:91];
			r_pick_q <= s_tdata[110:95];
			r_draw_q <= s_tdata[126:111];
			r_lag_q  <= s_tdata[142:127];
		end
		if (state_q == S_DECODE || state_q == S_LOSS_CHK) begin
			lo_q   <= bnd_lo;
			span_q <= SPW'(bnd_hi - bnd_lo) + 1'b1;
		end
		if (state_q == S_MUL_LOSS || state_q == S_MUL_LAG) begin
			prod_q <= span_q * mul_r;
		end
		if (state_q == S_TIME) begin
			t_q <= now_q + TIME_W'(pick_w[LAG_W-1:0]);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			occ_q        <= '0;
			pos_q        <= '0;
			j_q          <= '0;
			res_status_q <= ST_NONE;
			res_ip_q     <= '0;
			res_port_q   <= '0;
			res_len_q    <= '0;
			res_handle_q <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			m_status_q   <= ST_NONE;
		end else begin
			if (m_valid_q && m_tready && state_q != S_EMIT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						res_status_q <= ST_NONE;
						res_ip_q     <= '0;
						res_port_q   <= '0;
						res_len_q    <= '0;
						res_handle_q <= '0;
						state_q      <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (kind_q && len_q != '0 && !transparent) begin
						state_q <= S_MUL_LOSS;
					end else begin
						state_q <= S_EMIT;
					end
					if (!kind_q) begin
						// The head entry was read ahead while idle.
						if (!transparent && occ_q != '0 && at_or_after(now_q, rd_q.rel_time)) begin
							res_status_q <= ST_DELIVERED;
							res_ip_q     <= rd_q.ip;
							res_port_q   <= rd_q.port;
							res_len_q    <= rd_q.len;
							res_handle_q <= rd_q.handle;
							head_q       <= phys(head_q, LW'(1));
							occ_q        <= occ_q - 1'b1;
						end
					end else if (len_q != '0 && transparent) begin
						res_status_q <= ST_DELIVERED;
						res_ip_q     <= ip_q;
						res_port_q   <= port_q;
						res_len_q    <= len_q;
						res_handle_q <= handle_q;
					end
				end
				S_MUL_LOSS: begin
					state_q <= S_LOSS_CHK;
				end
				S_LOSS_CHK: begin
					if (SPW'(r_draw_q) < pick_w) begin
						res_status_q <= ST_DROPPED;
						res_handle_q <= handle_q;
						state_q      <= S_EMIT;
					end else if (occ_q == DEPTH_L) begin
						res_status_q <= ST_FULL;
						res_handle_q <= handle_q;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_MUL_LAG;
					end
				end
				S_MUL_LAG: begin
					state_q <= S_TIME;
				end
				S_TIME: begin
					pos_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// Entries whose release time is not after the new one stay ahead of it.
					if (scan_adv) begin
						pos_q <= pos_q + 1'b1;
					end else if (pos_q == occ_q) begin
						state_q <= S_WRITE;
					end else begin
						j_q     <= occ_q;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					j_q <= j_q - 1'b1;
					if ((j_q - 1'b1) == pos_q) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					occ_q        <= occ_q + 1'b1;
					res_status_q <= ST_QUEUED;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_data_q   <= {1'b0, res_handle_q, res_len_q, res_port_q, res_ip_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_L)
		else $error("occupancy above queue depth");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |=> occ_q == $past(occ_q) + 1'b1)
		else $error("insert did not grow occupancy by one");

	a_shift_above_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> (j_q > pos_q && j_q <= occ_q))
		else $error("shift index outside the moved region");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!m_valid_q || m_tready)) |=> (m_valid_q && state_q == S_IDLE))
		else $error("result not loaded into output register");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL_LAG |-> occ_q != DEPTH_L)
		else $error("insert started on a full queue");

endmodule
